// ===== rtl/abpb_pkg.sv =====
// Shared types, constants and colour arithmetic for the sprite pixel blitter.
package abpb_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int SCREEN_W        = 12;
	localparam int ORIGIN_W        = 16;
	localparam int CH_W            = 8;
	localparam int PROD_W          = 16;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_ADDR_W      = 5;

	localparam logic [SCREEN_W-1:0] WIDTH_RST  = 12'd320;
	localparam logic [SCREEN_W-1:0] HEIGHT_RST = 12'd240;
	localparam logic [CH_W-1:0]     ALPHA_MAX_CLEAR = 8'd63;
	localparam logic [PROD_W-1:0]   ROUND_HALF = 16'd127;

	typedef enum logic [2:0] {
		REG_ORIGIN_COL    = 3'd0,
		REG_ORIGIN_ROW    = 3'd1,
		REG_SCREEN_WIDTH  = 3'd2,
		REG_SCREEN_HEIGHT = 3'd3,
		REG_BRIGHTNESS    = 3'd4,
		REG_DITHER        = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		DIM_FULL      = 3'd0,
		DIM_3Q        = 3'd1,
		DIM_HALF      = 3'd2,
		DIM_QUARTER   = 3'd3,
		DIM_EIGHTH    = 3'd4,
		DIM_SIXTEENTH = 3'd5
	} dim_level_t;

	typedef struct packed {
		logic signed [ORIGIN_W-1:0] origin_col;
		logic signed [ORIGIN_W-1:0] origin_row;
		logic [SCREEN_W-1:0]        width;
		logic [SCREEN_W-1:0]        height;
		logic [2:0]                 level;
		logic                       dither;
	} cfg_t;

	// draw: visible pixel; paint: visible and not dithered to black
	typedef struct packed {
		logic                draw;
		logic                paint;
		logic [SCREEN_W-1:0] col;
		logic [SCREEN_W-1:0] row;
		logic [CH_W-1:0]     alpha;
		logic [CH_W-1:0]     red;
		logic [CH_W-1:0]     green;
		logic [CH_W-1:0]     blue;
		logic                eor;
	} pix_item_t;

	// floor(x / 255) for x below 65280 as ((x + 1) * 257) >> 16
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0]   x1;
		logic [PROD_W+8:0] m;
		x1 = {1'b0, x} + 17'd1;
		m  = {x1, 8'd0} + {8'd0, x1};
		return m[PROD_W+7:PROD_W];
	endfunction

	function automatic logic [CH_W-1:0] dim_channel(input logic [CH_W-1:0] c,
			input logic [2:0] level);
		logic [CH_W+1:0] t;
		t = {1'b0, c, 1'b0} + {2'b00, c} + 10'd2;
		case (level)
			DIM_3Q:        return t[CH_W+1:2];
			DIM_HALF:      return {1'b0, c[CH_W-1:1]};
			DIM_QUARTER:   return {2'b0, c[CH_W-1:2]};
			DIM_EIGHTH:    return {3'b0, c[CH_W-1:3]};
			DIM_SIXTEENTH: return {4'b0, c[CH_W-1:4]};
			default:       return c;
		endcase
	endfunction

	function automatic logic [15:0] pack565(input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

// ===== rtl/abpb_front.sv =====
// Front stage: place the pixel on screen, clip it and classify it for the queue.
module abpb_front #(
	parameter int COORD_BITS = abpb_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  abpb_pkg::cfg_t          cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_BITS-1:0]   img_col,
	input  logic [COORD_BITS-1:0]   img_row,
	input  logic [7:0]              alpha_in,
	input  logic [7:0]              red_in,
	input  logic [7:0]              green_in,
	input  logic [7:0]              blue_in,
	input  logic                    end_of_run,
	input  logic                    queue_full,
	output logic                    push,
	output logic                    stage_valid,
	output abpb_pkg::pix_item_t     item
);
	import abpb_pkg::*;

	localparam int SUM_W = ((COORD_BITS + 1 > ORIGIN_W) ? COORD_BITS + 1 : ORIGIN_W) + 1;

	logic signed [SUM_W-1:0] sx;
	logic signed [SUM_W-1:0] sy;
	logic                    on_x;
	logic                    on_y;
	logic                    visible;
	logic                    black;
	pix_item_t               item_d;
	pix_item_t               item_s1;
	logic                    valid_s1;

	always_comb begin
		sx = SUM_W'(cfg.origin_col) + $signed(SUM_W'(img_col));
		sy = SUM_W'(cfg.origin_row) + $signed(SUM_W'(img_row));
		on_x = !sx[SUM_W-1] && (sx[SUM_W-2:0] < (SUM_W-1)'(cfg.width));
		on_y = !sy[SUM_W-1] && (sy[SUM_W-2:0] < (SUM_W-1)'(cfg.height));
		visible = on_x && on_y && (alpha_in > ALPHA_MAX_CLEAR);
		black = cfg.dither && (sx[0] ^ sy[0]);
		item_d.draw  = visible;
		item_d.paint = visible && !black;
		item_d.col   = visible ? sx[SCREEN_W-1:0] : '0;
		item_d.row   = visible ? sy[SCREEN_W-1:0] : '0;
		item_d.alpha = alpha_in;
		item_d.red   = red_in;
		item_d.green = green_in;
		item_d.blue  = blue_in;
		item_d.eor   = end_of_run;
	end

	assign push        = valid_s1 && !queue_full;
	assign in_ready    = !valid_s1 || !queue_full;
	assign stage_valid = valid_s1;
	assign item        = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/abpb_fifo.sv =====
// Short request queue between the front and back stages.
module abpb_fifo #(
	parameter int DEPTH = abpb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  abpb_pkg::pix_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output abpb_pkg::pix_item_t pop_item
);
	import abpb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pix_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != CNT_W'(DEPTH)))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not advance on write");
`endif

endmodule

// ===== rtl/abpb_back.sv =====
// Back stages: premultiply by alpha, dim, pack to RGB565 and hold the result.
module abpb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          level,
	input  logic                req_valid,
	output logic                pop,
	input  abpb_pkg::pix_item_t req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                write_enable,
	output logic [11:0]         screen_col,
	output logic [11:0]         screen_row,
	output logic [15:0]         color565,
	output logic                run_done
);
	import abpb_pkg::*;

	logic                valid_s1;
	logic                valid_s2;
	logic                take_s1;
	logic                take_s2;
	logic [PROD_W-1:0]   prod_r_s1;
	logic [PROD_W-1:0]   prod_g_s1;
	logic [PROD_W-1:0]   prod_b_s1;
	logic                draw_s1;
	logic                paint_s1;
	logic [SCREEN_W-1:0] col_s1;
	logic [SCREEN_W-1:0] row_s1;
	logic                eor_s1;
	logic [15:0]         color_d;
	logic                draw_s2;
	logic [SCREEN_W-1:0] col_s2;
	logic [SCREEN_W-1:0] row_s2;
	logic [15:0]         color_s2;
	logic                eor_s2;

	assign take_s2 = !valid_s2 || out_ready;
	assign take_s1 = !valid_s1 || take_s2;
	assign pop     = req_valid && take_s1;

	always_comb begin
		color_d = pack565(dim_channel(div255(prod_r_s1), level),
			dim_channel(div255(prod_g_s1), level),
			dim_channel(div255(prod_b_s1), level));
		if (!paint_s1) begin
			color_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= req_valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_r_s1 <= {8'd0, req.red} * {8'd0, req.alpha} + ROUND_HALF;
			prod_g_s1 <= {8'd0, req.green} * {8'd0, req.alpha} + ROUND_HALF;
			prod_b_s1 <= {8'd0, req.blue} * {8'd0, req.alpha} + ROUND_HALF;
			draw_s1   <= req.draw;
			paint_s1  <= req.paint;
			col_s1    <= req.col;
			row_s1    <= req.row;
			eor_s1    <= req.eor;
		end
		if (take_s2 && valid_s1) begin
			draw_s2  <= draw_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			color_s2 <= color_d;
			eor_s2   <= eor_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = draw_s2;
	assign screen_col   = col_s2;
	assign screen_row   = row_s2;
	assign color565     = color_s2;
	assign run_done     = eor_s2;

endmodule

// ===== rtl/argb_pixel_blit_rgb565.sv =====
// Top level of the sprite pixel blitter: register port, front, queue and back.
// Throughput: one pixel per clock while the output is not stalled; each request
// yields one result. A pixel is registered in turn in the front stage, a queue
// slot, the multiply stage and the output register.
// The queue holds QUEUE_DEPTH requests so the front keeps taking pixels while the
// output is stalled; input stalls only once the front stage and queue are full.
// Reset (arst_n low) empties all stages and loads the registers with their defaults.
module argb_pixel_blit_rgb565 #(
	parameter int COORD_BITS  = abpb_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = abpb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [abpb_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [abpb_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [abpb_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [COORD_BITS-1:0]               img_col,
	input  logic [COORD_BITS-1:0]               img_row,
	input  logic [7:0]                          alpha_in,
	input  logic [7:0]                          red_in,
	input  logic [7:0]                          green_in,
	input  logic [7:0]                          blue_in,
	input  logic                                end_of_run,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                write_enable,
	output logic [11:0]                         screen_col,
	output logic [11:0]                         screen_row,
	output logic [15:0]                         color565,
	output logic                                run_done
);
	import abpb_pkg::*;

	cfg_t      cfg_q;
	logic      cfg_wr;
	reg_idx_t  reg_sel;
	logic      queue_full;
	logic      queue_push;
	logic      queue_pop;
	logic      queue_not_empty;
	logic      front_valid;
	pix_item_t front_item;
	pix_item_t queue_item;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_col <= '0;
			cfg_q.origin_row <= '0;
			cfg_q.width      <= WIDTH_RST;
			cfg_q.height     <= HEIGHT_RST;
			cfg_q.level      <= DIM_FULL;
			cfg_q.dither     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ORIGIN_COL:    cfg_q.origin_col <= pwdata[ORIGIN_W-1:0];
				REG_ORIGIN_ROW:    cfg_q.origin_row <= pwdata[ORIGIN_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.width      <= pwdata[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.height     <= pwdata[SCREEN_W-1:0];
				REG_BRIGHTNESS:    cfg_q.level      <= pwdata[2:0];
				REG_DITHER:        cfg_q.dither     <= pwdata[0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ORIGIN_COL:    prdata = CFG_DATA_W'(cfg_q.origin_col);
			REG_ORIGIN_ROW:    prdata = CFG_DATA_W'(cfg_q.origin_row);
			REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(cfg_q.width);
			REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(cfg_q.height);
			REG_BRIGHTNESS:    prdata = CFG_DATA_W'(cfg_q.level);
			REG_DITHER:        prdata = CFG_DATA_W'(cfg_q.dither);
			default:           prdata = '0;
		endcase
	end

	abpb_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.img_col    (img_col),
		.img_row    (img_row),
		.alpha_in   (alpha_in),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.end_of_run (end_of_run),
		.queue_full (queue_full),
		.push       (queue_push),
		.stage_valid(front_valid),
		.item       (front_item)
	);

	abpb_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (queue_push),
		.push_item(front_item),
		.full     (queue_full),
		.pop      (queue_pop),
		.not_empty(queue_not_empty),
		.pop_item (queue_item)
	);

	abpb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.level       (cfg_q.level),
		.req_valid   (queue_not_empty),
		.pop         (queue_pop),
		.req         (queue_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.write_enable(write_enable),
		.screen_col  (screen_col),
		.screen_row  (screen_row),
		.color565    (color565),
		.run_done    (run_done)
	);

`ifndef ASSERT_OFF
	a_skip_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |->
			(color565 == '0 && screen_col == '0 && screen_row == '0))
		else $error("skipped pixel carries coordinates or colour");
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (front_valid && queue_full))
		else $error("input stalled with room downstream");
	a_room_means_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!queue_full |-> in_ready)
		else $error("input not ready while queue has room");
`endif

endmodule
